@@ hw/rtl/i2cmbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2cmbe_pkg;

   localparam int HALF_PERIOD_RESET = 3;
   localparam int ACK_TIMEOUT_RESET = 200;

   typedef enum logic [0:0] {
      CSR_HALF_PERIOD = 1'b0,
      CSR_ACK_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_ACK   = 3'd4,
      OP_NACK  = 3'd5
   } op_type;

   typedef enum logic [4:0] {
      PH_IDLE         = 5'd0,
      PH_STA_HIGH     = 5'd1,
      PH_STA_SDA_LOW  = 5'd2,
      PH_STA_SCL_LOW  = 5'd3,
      PH_STO_SETUP    = 5'd4,
      PH_STO_HIGH     = 5'd5,
      PH_WR_HOLD      = 5'd6,
      PH_WR_DATA      = 5'd7,
      PH_WR_HIGH      = 5'd8,
      PH_WR_END       = 5'd9,
      PH_WR_RELEASE   = 5'd10,
      PH_WR_POLL      = 5'd11,
      PH_WR_ACK_HIGH  = 5'd12,
      PH_WR_ACK_LOW   = 5'd13,
      PH_RD_RELEASE   = 5'd14,
      PH_RD_SAMPLE    = 5'd15,
      PH_RD_HIGH      = 5'd16,
      PH_RD_LOW       = 5'd17,
      PH_RD_RECLAIM   = 5'd18,
      PH_AK_SETUP     = 5'd19,
      PH_AK_HIGH      = 5'd20,
      PH_AK_LOW       = 5'd21,
      PH_FIN          = 5'd22
   } phase_type;

   // Line levels lead the packed result as {scl, sda, drive}.
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/i2c_master_bit_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// I2C master byte engine. Each transaction on the req_ channel is one bus tick: it carries
// the sampled SDA level and, while the engine is idle, an optional command (start, stop,
// write byte with acknowledge detect, read byte, send ack, send nack). Each accepted tick
// produces exactly one transaction on the rsp_ channel with the SCL level, SDA level and
// SDA enable for that tick, plus busy, done, the last received byte and the ack flag.
// The result of a tick is registered in the output register, or in the skid register while the
// output register is held, and one tick can be accepted every cycle while req_stall is low.
// An output register plus a skid register hold up to two results; req_stall rises only
// when both are full, so a stalled receiver back-pressures the sender after two ticks.
// Bus timing is counted in accepted ticks, not in clock cycles, so stalls do not change
// the waveform. The csr_ port writes half_period (index 0) and ack_timeout (index 1);
// writes are meant for idle periods and take effect on the next tick.
// Synchronous reset returns the engine to idle with SCL high and SDA driven high,
// half_period at 3, ack_timeout at 200, and both result registers empty.
module i2c_master_bit_engine_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd_valid,
   input  wire logic [2:0]  req_func,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_sda_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_level,
   output logic             rsp_sda_level,
   output logic             rsp_sda_drive,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_rx_byte,
   output logic             rsp_ack_seen,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   function automatic logic [2:0] mk_line(input logic scl, input logic sda, input logic drv);
      return {drv, sda & drv, scl};
   endfunction

   logic [7:0]  half_period_ff;
   logic [15:0] ack_timeout_ff;

   i2cmbe_pkg::phase_type phase_ff, phase_in, act_phase, nxt_phase;
   i2cmbe_pkg::op_type    op_ff, op_in, act_op;
   logic [15:0] tick_ff, tick_in, act_tick, tick_inc;
   logic [3:0]  bit_ff, bit_in, act_bit, bit_inc;
   logic [7:0]  shift_ff, shift_in, act_shift;
   logic        ack_ff, ack_in, act_ack;
   logic [7:0]  rx_ff, rx_in;
   logic [2:0]  line_ff, line_in, line_lv;
   logic        busy_v, done_v, advance_v;
   logic [7:0]  dval;
   logic [8:0]  seg_len;

   i2cmbe_pkg::result_type out_ff, out_in, skid_ff, skid_in, result_v;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic tick_go, drain;

   assign tick_go   = req_valid & ~skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign drain     = out_valid_ff & ~rsp_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= 8'(i2cmbe_pkg::HALF_PERIOD_RESET);
         ack_timeout_ff <= 16'(i2cmbe_pkg::ACK_TIMEOUT_RESET);
      end else if (csr_we) begin
         case (i2cmbe_pkg::csr_index_type'(csr_index))
            i2cmbe_pkg::CSR_HALF_PERIOD: half_period_ff <= csr_wdata[7:0];
            i2cmbe_pkg::CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Command acceptance: the state seen by this tick's bus segment.
   always_comb begin
      act_phase = phase_ff;
      act_op    = op_ff;
      act_tick  = tick_ff;
      act_bit   = bit_ff;
      act_shift = shift_ff;
      act_ack   = ack_ff;
      if (phase_ff == i2cmbe_pkg::PH_IDLE && req_cmd_valid &&
          req_func <= 3'(i2cmbe_pkg::OP_NACK)) begin
         act_op   = i2cmbe_pkg::op_type'(req_func);
         act_bit  = 4'd0;
         act_tick = 16'd0;
         case (act_op)
            i2cmbe_pkg::OP_START: act_phase = i2cmbe_pkg::PH_STA_HIGH;
            i2cmbe_pkg::OP_STOP:  act_phase = i2cmbe_pkg::PH_STO_SETUP;
            i2cmbe_pkg::OP_WRITE: begin
               act_shift = req_tx_byte;
               act_ack   = 1'b0;
               act_phase = i2cmbe_pkg::PH_WR_HOLD;
            end
            i2cmbe_pkg::OP_READ: begin
               act_shift = 8'd0;
               act_phase = i2cmbe_pkg::PH_RD_RELEASE;
            end
            default: act_phase = i2cmbe_pkg::PH_AK_SETUP;
         endcase
      end
   end

   // Segment length of the active phase.
   always_comb begin
      dval = (half_period_ff == 8'd0) ? 8'd1 : half_period_ff;
      case (act_phase)
         i2cmbe_pkg::PH_WR_RELEASE, i2cmbe_pkg::PH_RD_RELEASE:
            seg_len = {1'b0, dval} + 9'd2;
         i2cmbe_pkg::PH_WR_ACK_LOW: seg_len = {2'b00, dval[7:1]};
         default: seg_len = {1'b0, dval};
      endcase
   end

   // Output block: line levels, busy and done for the active phase.
   always_comb begin
      busy_v  = 1'b0;
      done_v  = 1'b0;
      line_lv = line_ff;
      if (act_phase == i2cmbe_pkg::PH_FIN) begin
         done_v = 1'b1;
         if (act_op == i2cmbe_pkg::OP_STOP) begin
            line_lv = mk_line(1'b1, 1'b1, 1'b1);
         end else if (act_op >= i2cmbe_pkg::OP_ACK) begin
            line_lv = mk_line(1'b0, 1'b1, 1'b1);
         end
      end else if (act_phase != i2cmbe_pkg::PH_IDLE) begin
         busy_v = 1'b1;
         case (act_phase)
            i2cmbe_pkg::PH_STA_HIGH:    line_lv = mk_line(1'b1, 1'b1, 1'b1);
            i2cmbe_pkg::PH_STA_SDA_LOW: line_lv = mk_line(1'b1, 1'b0, 1'b1);
            i2cmbe_pkg::PH_STA_SCL_LOW: line_lv = mk_line(1'b0, 1'b0, 1'b1);
            i2cmbe_pkg::PH_STO_SETUP:   line_lv = mk_line(line_ff[0], 1'b0, 1'b1);
            i2cmbe_pkg::PH_STO_HIGH:    line_lv = mk_line(1'b1, 1'b0, 1'b1);
            i2cmbe_pkg::PH_WR_HOLD,
            i2cmbe_pkg::PH_WR_END:      line_lv = mk_line(1'b0, line_ff[1], 1'b1);
            i2cmbe_pkg::PH_WR_DATA:     line_lv = mk_line(1'b0, act_shift[7], 1'b1);
            i2cmbe_pkg::PH_WR_HIGH:     line_lv = mk_line(1'b1, act_shift[7], 1'b1);
            i2cmbe_pkg::PH_WR_RELEASE,
            i2cmbe_pkg::PH_WR_POLL,
            i2cmbe_pkg::PH_RD_RELEASE,
            i2cmbe_pkg::PH_RD_LOW:      line_lv = mk_line(1'b0, 1'b0, 1'b0);
            i2cmbe_pkg::PH_WR_ACK_HIGH: line_lv = mk_line(1'b1, 1'b0, 1'b1);
            i2cmbe_pkg::PH_WR_ACK_LOW,
            i2cmbe_pkg::PH_RD_RECLAIM:  line_lv = mk_line(1'b0, 1'b0, 1'b1);
            i2cmbe_pkg::PH_RD_SAMPLE,
            i2cmbe_pkg::PH_RD_HIGH:     line_lv = mk_line(1'b1, 1'b0, 1'b0);
            i2cmbe_pkg::PH_AK_SETUP:
               line_lv = mk_line(line_ff[0], act_op == i2cmbe_pkg::OP_NACK, 1'b1);
            i2cmbe_pkg::PH_AK_HIGH:
               line_lv = mk_line(1'b1, act_op == i2cmbe_pkg::OP_NACK, 1'b1);
            default:
               line_lv = mk_line(1'b0, act_op == i2cmbe_pkg::OP_NACK, 1'b1);
         endcase
      end
   end

   assign tick_inc = act_tick + 16'd1;
   assign bit_inc  = act_bit + 4'd1;

   // Next-state block.
   always_comb begin
      phase_in  = phase_ff;
      op_in     = op_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      ack_in    = ack_ff;
      rx_in     = rx_ff;
      line_in   = line_ff;
      advance_v = 1'b0;
      nxt_phase = act_phase;
      if (tick_go) begin
         phase_in = act_phase;
         op_in    = act_op;
         tick_in  = act_tick;
         bit_in   = act_bit;
         shift_in = act_shift;
         ack_in   = act_ack;
         line_in  = line_lv;
         if (act_phase == i2cmbe_pkg::PH_FIN) begin
            phase_in = i2cmbe_pkg::PH_IDLE;
            tick_in  = 16'd0;
         end else if (act_phase != i2cmbe_pkg::PH_IDLE) begin
            if (act_phase == i2cmbe_pkg::PH_WR_POLL) begin
               if (!req_sda_in) begin
                  ack_in    = 1'b1;
                  advance_v = 1'b1;
               end else begin
                  tick_in   = tick_inc;
                  advance_v = (tick_inc >= ack_timeout_ff);
               end
            end else begin
               if (act_phase == i2cmbe_pkg::PH_RD_SAMPLE &&
                   ({1'b0, act_tick} + 17'd1) >= {8'd0, seg_len}) begin
                  shift_in = {act_shift[6:0], req_sda_in};
               end
               tick_in   = tick_inc;
               advance_v = (tick_inc >= {7'd0, seg_len});
            end
            if (advance_v) begin
               case (act_phase)
                  i2cmbe_pkg::PH_STA_SCL_LOW, i2cmbe_pkg::PH_STO_HIGH,
                  i2cmbe_pkg::PH_WR_ACK_LOW, i2cmbe_pkg::PH_RD_RECLAIM,
                  i2cmbe_pkg::PH_AK_LOW:
                     nxt_phase = i2cmbe_pkg::PH_FIN;
                  i2cmbe_pkg::PH_WR_HIGH: begin
                     shift_in  = {act_shift[6:0], 1'b0};
                     bit_in    = bit_inc;
                     nxt_phase = (bit_inc < 4'd8) ? i2cmbe_pkg::PH_WR_HOLD
                                                  : i2cmbe_pkg::PH_WR_END;
                  end
                  i2cmbe_pkg::PH_RD_LOW: begin
                     bit_in = bit_inc;
                     if (bit_inc < 4'd8) begin
                        nxt_phase = i2cmbe_pkg::PH_RD_SAMPLE;
                     end else begin
                        nxt_phase = i2cmbe_pkg::PH_RD_RECLAIM;
                        rx_in     = act_shift;
                     end
                  end
                  default: nxt_phase = i2cmbe_pkg::phase_type'(5'(act_phase) + 5'd1);
               endcase
               tick_in = 16'd0;
               if (nxt_phase == i2cmbe_pkg::PH_WR_POLL && ack_timeout_ff == 16'd0) begin
                  nxt_phase = i2cmbe_pkg::PH_WR_ACK_HIGH;
               end
               if (nxt_phase == i2cmbe_pkg::PH_WR_ACK_LOW && dval[7:1] == 7'd0) begin
                  nxt_phase = i2cmbe_pkg::PH_FIN;
               end
               phase_in = nxt_phase;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cmbe_pkg::PH_IDLE;
         op_ff    <= i2cmbe_pkg::OP_START;
         tick_ff  <= 16'd0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         ack_ff   <= 1'b0;
         rx_ff    <= 8'd0;
         line_ff  <= 3'b111;
      end else begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         ack_ff   <= ack_in;
         rx_ff    <= rx_in;
         line_ff  <= line_in;
      end
   end

   // Result of this tick and the output register with its skid stage.
   always_comb begin
      result_v.scl_level = line_in[0];
      result_v.sda_level = line_in[1];
      result_v.sda_drive = line_in[2];
      result_v.busy_res  = busy_v;
      result_v.done_res  = done_v;
      result_v.rx_byte   = rx_in;
      result_v.ack_seen  = ack_in;
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (tick_go) begin
         if (!out_valid_ff || drain) begin
            out_in       = result_v;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result_v;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_level = out_ff.scl_level;
   assign rsp_sda_level = out_ff.sda_level;
   assign rsp_sda_drive = out_ff.sda_drive;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_rx_byte   = out_ff.rx_byte;
   assign rsp_ack_seen  = out_ff.ack_seen;

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= 4'd8)
      else $error("bit counter ran past eight");

   a_fin_returns_idle: assert property (@(posedge clock) disable iff (reset)
      tick_go && phase_ff == i2cmbe_pkg::PH_FIN |=> phase_ff == i2cmbe_pkg::PH_IDLE)
      else $error("finishing tick did not return the engine to idle");

   a_released_sda_low: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.sda_drive |-> !out_ff.sda_level)
      else $error("SDA level set while the line is released");

endmodule

`default_nettype wire

@@ bench/i2c_master_bit_engine_top_tb.sv @@
`timescale 1ns / 1ps

module i2c_master_bit_engine_top_tb;

   localparam logic [2:0] FUNC_RESERVED_6 = 3'd6;
   localparam logic [2:0] FUNC_RESERVED_7 = 3'd7;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] func;
      logic [7:0] tx_byte;
      logic       sda_in;
   } bus_tick_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd_valid = 1'b0;
   logic [2:0]  req_func = '0;
   logic [7:0]  req_tx_byte = '0;
   logic        req_sda_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_sda_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_ack_seen;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   i2c_master_bit_engine_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd_valid (req_cmd_valid),
      .req_func      (req_func),
      .req_tx_byte   (req_tx_byte),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl_level (rsp_scl_level),
      .rsp_sda_level (rsp_sda_level),
      .rsp_sda_drive (rsp_sda_drive),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_ack_seen  (rsp_ack_seen),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   bus_tick_type           pending_ticks[$];
   i2cmbe_pkg::result_type expected_results[$];
   bus_tick_type           offered;
   i2cmbe_pkg::result_type oldest_result;
   int         queued_ticks = 0;
   int         errors = 0;
   int         rsp_count = 0;
   bit         quiet = 1'b0;
   int         gap_left = 0;
   int         send_odds = 0;
   int         burst_left = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;
   int         stall_odds = 0;

   logic [7:0]  half_period = 8'(i2cmbe_pkg::HALF_PERIOD_RESET);
   logic [15:0] ack_timeout = 16'(i2cmbe_pkg::ACK_TIMEOUT_RESET);
   i2cmbe_pkg::phase_type eng_phase = i2cmbe_pkg::PH_IDLE;
   logic [15:0] tick_cnt = '0;
   logic [3:0]  bit_cnt = '0;
   logic [7:0]  shifter = '0;
   i2cmbe_pkg::op_type cur_op = i2cmbe_pkg::OP_START;
   logic        ack_flag = 1'b0;
   logic [7:0]  rx_data = '0;
   logic [2:0]  lines = 3'b111;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [2:0] levels(logic scl, logic sda, logic drv);
      return {drv, sda & drv, scl};
   endfunction

   function automatic logic [8:0] phase_ticks(i2cmbe_pkg::phase_type p);
      logic [8:0] d;
      d = (half_period == 8'd0) ? 9'd1 : {1'b0, half_period};
      if (p == i2cmbe_pkg::PH_WR_RELEASE || p == i2cmbe_pkg::PH_RD_RELEASE) begin
         return d + 9'd2;
      end
      if (p == i2cmbe_pkg::PH_WR_ACK_LOW) return d >> 1;
      return d;
   endfunction

   function automatic void enter_phase(i2cmbe_pkg::phase_type p);
      tick_cnt = '0;
      if (p == i2cmbe_pkg::PH_WR_POLL && ack_timeout == 16'd0) p = i2cmbe_pkg::PH_WR_ACK_HIGH;
      if (p == i2cmbe_pkg::PH_WR_ACK_LOW && phase_ticks(p) == 9'd0) p = i2cmbe_pkg::PH_FIN;
      eng_phase = p;
   endfunction

   function automatic void advance_phase();
      i2cmbe_pkg::phase_type n;
      case (eng_phase)
         i2cmbe_pkg::PH_STA_SCL_LOW, i2cmbe_pkg::PH_STO_HIGH, i2cmbe_pkg::PH_WR_ACK_LOW,
         i2cmbe_pkg::PH_RD_RECLAIM, i2cmbe_pkg::PH_AK_LOW: n = i2cmbe_pkg::PH_FIN;
         i2cmbe_pkg::PH_WR_HIGH: begin
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 4'd1;
            n = (bit_cnt < 4'd8) ? i2cmbe_pkg::PH_WR_HOLD : i2cmbe_pkg::PH_WR_END;
         end
         i2cmbe_pkg::PH_RD_LOW: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < 4'd8) begin
               n = i2cmbe_pkg::PH_RD_SAMPLE;
            end else begin
               n = i2cmbe_pkg::PH_RD_RECLAIM;
               rx_data = shifter;
            end
         end
         default: n = i2cmbe_pkg::phase_type'(eng_phase + 5'd1);
      endcase
      enter_phase(n);
   endfunction

   function automatic i2cmbe_pkg::result_type predict_tick(bus_tick_type it);
      i2cmbe_pkg::result_type r;
      logic       scl;
      logic       sda;
      logic       bit_out;
      logic       a;
      logic [8:0] len;
      r = '0;
      if (eng_phase == i2cmbe_pkg::PH_IDLE && it.cmd_valid && it.func <= i2cmbe_pkg::OP_NACK) begin
         cur_op = i2cmbe_pkg::op_type'(it.func);
         bit_cnt = '0;
         case (cur_op)
            i2cmbe_pkg::OP_START: enter_phase(i2cmbe_pkg::PH_STA_HIGH);
            i2cmbe_pkg::OP_STOP: enter_phase(i2cmbe_pkg::PH_STO_SETUP);
            i2cmbe_pkg::OP_WRITE: begin
               shifter = it.tx_byte;
               ack_flag = 1'b0;
               enter_phase(i2cmbe_pkg::PH_WR_HOLD);
            end
            i2cmbe_pkg::OP_READ: begin
               shifter = '0;
               enter_phase(i2cmbe_pkg::PH_RD_RELEASE);
            end
            default: enter_phase(i2cmbe_pkg::PH_AK_SETUP);
         endcase
      end
      if (eng_phase == i2cmbe_pkg::PH_FIN) begin
         if (cur_op == i2cmbe_pkg::OP_STOP) begin
            lines = levels(1'b1, 1'b1, 1'b1);
         end else if (cur_op == i2cmbe_pkg::OP_ACK || cur_op == i2cmbe_pkg::OP_NACK) begin
            lines = levels(1'b0, 1'b1, 1'b1);
         end
         r.done_res = 1'b1;
         eng_phase = i2cmbe_pkg::PH_IDLE;
         tick_cnt = '0;
      end else if (eng_phase != i2cmbe_pkg::PH_IDLE) begin
         scl = lines[0];
         sda = lines[1];
         bit_out = shifter[7];
         a = (cur_op == i2cmbe_pkg::OP_NACK);
         r.busy_res = 1'b1;
         case (eng_phase)
            i2cmbe_pkg::PH_STA_HIGH: lines = levels(1'b1, 1'b1, 1'b1);
            i2cmbe_pkg::PH_STA_SDA_LOW, i2cmbe_pkg::PH_STO_HIGH,
            i2cmbe_pkg::PH_WR_ACK_HIGH: lines = levels(1'b1, 1'b0, 1'b1);
            i2cmbe_pkg::PH_STA_SCL_LOW, i2cmbe_pkg::PH_WR_ACK_LOW,
            i2cmbe_pkg::PH_RD_RECLAIM: lines = levels(1'b0, 1'b0, 1'b1);
            i2cmbe_pkg::PH_STO_SETUP: lines = levels(scl, 1'b0, 1'b1);
            i2cmbe_pkg::PH_WR_HOLD, i2cmbe_pkg::PH_WR_END: lines = levels(1'b0, sda, 1'b1);
            i2cmbe_pkg::PH_WR_DATA: lines = levels(1'b0, bit_out, 1'b1);
            i2cmbe_pkg::PH_WR_HIGH: lines = levels(1'b1, bit_out, 1'b1);
            i2cmbe_pkg::PH_WR_RELEASE, i2cmbe_pkg::PH_WR_POLL, i2cmbe_pkg::PH_RD_RELEASE,
            i2cmbe_pkg::PH_RD_LOW: begin
               lines = levels(1'b0, 1'b0, 1'b0);
            end
            i2cmbe_pkg::PH_RD_SAMPLE, i2cmbe_pkg::PH_RD_HIGH: lines = levels(1'b1, 1'b0, 1'b0);
            i2cmbe_pkg::PH_AK_SETUP: lines = levels(scl, a, 1'b1);
            i2cmbe_pkg::PH_AK_HIGH: lines = levels(1'b1, a, 1'b1);
            default: lines = levels(1'b0, a, 1'b1);
         endcase
         if (eng_phase == i2cmbe_pkg::PH_WR_POLL) begin
            if (!it.sda_in) begin
               ack_flag = 1'b1;
               advance_phase();
            end else begin
               tick_cnt = tick_cnt + 16'd1;
               if (tick_cnt >= ack_timeout) advance_phase();
            end
         end else begin
            len = phase_ticks(eng_phase);
            if (eng_phase == i2cmbe_pkg::PH_RD_SAMPLE && int'(tick_cnt) + 1 >= int'(len)) begin
               shifter = {shifter[6:0], it.sda_in};
            end
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= {7'd0, len}) advance_phase();
         end
      end
      r.scl_level = lines[0];
      r.sda_level = lines[1];
      r.sda_drive = lines[2];
      r.rx_byte = rx_data;
      r.ack_seen = ack_flag;
      return r;
   endfunction

   // Rough length of a command in ticks, so that most commands find the engine idle.
   function automatic int command_ticks(logic [2:0] func, int high_pct);
      int d;
      int poll;
      d = (half_period == 8'd0) ? 1 : int'(half_period);
      if (ack_timeout == 16'd0) poll = 0;
      else if (high_pct >= 100 || ack_timeout < 16'd16) poll = int'(ack_timeout);
      else poll = 16;
      case (func)
         i2cmbe_pkg::OP_START, i2cmbe_pkg::OP_ACK, i2cmbe_pkg::OP_NACK: return 3 * d + 1;
         i2cmbe_pkg::OP_STOP: return 2 * d + 1;
         i2cmbe_pkg::OP_WRITE: return 27 * d + 3 + poll + d / 2;
         i2cmbe_pkg::OP_READ: return 26 * d + 3;
         default: return 0;
      endcase
   endfunction

   task automatic issue_command(logic [2:0] func, logic [7:0] data, int high_pct, bit noise);
      bus_tick_type t;
      int           n;
      n = command_ticks(func, high_pct) + $urandom_range(0, 3);
      t.cmd_valid = 1'b1;
      t.func = func;
      t.tx_byte = data;
      t.sda_in = ($urandom_range(0, 99) < high_pct);
      pending_ticks.push_back(t);
      repeat (n) begin
         t.cmd_valid = noise && ($urandom_range(0, 7) == 0);
         t.func = 3'($urandom_range(0, 7));
         t.tx_byte = 8'($urandom);
         t.sda_in = ($urandom_range(0, 99) < high_pct);
         pending_ticks.push_back(t);
      end
      queued_ticks += n + 1;
   endtask

   function automatic int sda_high_pct();
      return (ack_timeout > 16'd300) ? $urandom_range(0, 90) : $urandom_range(0, 100);
   endfunction

   task automatic random_traffic(int budget);
      int  target;
      bit  noise;
      target = queued_ticks + budget;
      while (queued_ticks < target) begin
         if ($urandom_range(0, 99) < 85) begin
            noise = ($urandom_range(0, 3) == 0);
            issue_command(i2cmbe_pkg::OP_START, 8'($urandom), sda_high_pct(), noise);
            issue_command(i2cmbe_pkg::OP_WRITE, 8'($urandom), sda_high_pct(), noise);
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 1) == 1) begin
                  issue_command(i2cmbe_pkg::OP_WRITE, 8'($urandom), sda_high_pct(), noise);
               end else begin
                  issue_command(i2cmbe_pkg::OP_READ, 8'($urandom), sda_high_pct(), noise);
                  issue_command($urandom_range(0, 1) ? i2cmbe_pkg::OP_ACK : i2cmbe_pkg::OP_NACK,
                                8'($urandom), sda_high_pct(), noise);
               end
            end
            issue_command(i2cmbe_pkg::OP_STOP, 8'($urandom), sda_high_pct(), noise);
         end else begin
            issue_command(3'($urandom_range(0, 7)), 8'($urandom), sda_high_pct(), 1'b1);
         end
      end
   endtask

   task automatic wait_for_results();
      while (pending_ticks.size() != 0 || expected_results.size() != 0 || req_valid) begin
         @(posedge clock);
      end
   endtask

   // The engine must also be back in idle before a register changes.
   task automatic drain_bus();
      wait_for_results();
      while (eng_phase != i2cmbe_pkg::PH_IDLE) begin
         repeat (32) pending_ticks.push_back('0);
         wait_for_results();
      end
   endtask

   task automatic write_reg(i2cmbe_pkg::csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == i2cmbe_pkg::CSR_HALF_PERIOD) half_period = value[7:0];
      else ack_timeout = value;
   endtask

   task automatic set_config(logic [7:0] hp, logic [15:0] at);
      write_reg(i2cmbe_pkg::CSR_HALF_PERIOD, {8'($urandom), hp});
      write_reg(i2cmbe_pkg::CSR_ACK_TIMEOUT, at);
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) expected_results.push_back(predict_tick(offered));
         if ($urandom_range(0, 63) == 0) send_odds = $urandom_range(0, 2);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               offered = pending_ticks.pop_front();
               req_cmd_valid <= offered.cmd_valid;
               req_func <= offered.func;
               req_tx_byte <= offered.tx_byte;
               req_sda_in <= offered.sda_in;
               req_valid <= 1'b1;
               if (!quiet && send_odds != 0 && $urandom_range(0, 4 * send_odds) == 0) begin
                  gap_left = $urandom_range(1, 13);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_results.size() == 0) begin
               $error("result transaction arrived with no expectation waiting");
               errors++;
            end else begin
               oldest_result = expected_results.pop_front();
               check_field("scl_level", 8'(oldest_result.scl_level), 8'(rsp_scl_level));
               check_field("sda_level", 8'(oldest_result.sda_level), 8'(rsp_sda_level));
               check_field("sda_drive", 8'(oldest_result.sda_drive), 8'(rsp_sda_drive));
               check_field("busy_res", 8'(oldest_result.busy_res), 8'(rsp_busy_res));
               check_field("done_res", 8'(oldest_result.done_res), 8'(rsp_done_res));
               check_field("rx_byte", oldest_result.rx_byte, rsp_rx_byte);
               check_field("ack_seen", 8'(oldest_result.ack_seen), 8'(rsp_ack_seen));
            end
         end
         if ($urandom_range(0, 63) == 0) stall_odds = $urandom_range(0, 2);
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rsp_count >= 300 && pending_ticks.size() > 16) begin
            // A long hold-off lets the sender fill the engine until it stalls its input.
            hold_done = 1'b1;
            hold_left = 199;
            rsp_stall <= 1'b1;
         end else if (burst_left != 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && stall_odds != 0 && $urandom_range(0, 4 * stall_odds) == 0) begin
            burst_left = $urandom_range(0, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      logic [7:0]  hp_list[3];
      logic [15:0] at_list[3];
      hp_list = '{8'd1, 8'd0, 8'd2};
      at_list = '{16'd0, 16'd1, 16'd65535};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      issue_command(i2cmbe_pkg::OP_START, 8'h00, 50, 1'b0);
      issue_command(i2cmbe_pkg::OP_WRITE, 8'hA5, 0, 1'b1);
      issue_command(i2cmbe_pkg::OP_READ, 8'h00, 50, 1'b0);
      issue_command(i2cmbe_pkg::OP_ACK, 8'h00, 50, 1'b1);
      issue_command(i2cmbe_pkg::OP_NACK, 8'h00, 50, 1'b0);
      issue_command(i2cmbe_pkg::OP_STOP, 8'h00, 50, 1'b0);
      issue_command(FUNC_RESERVED_6, 8'h00, 50, 1'b0);
      issue_command(FUNC_RESERVED_7, 8'hFF, 50, 1'b0);
      drain_bus();

      for (int i = 0; i < 3; i++) begin
         set_config(hp_list[i], at_list[i]);
         random_traffic(100);
         drain_bus();
      end

      quiet = 1'b1;
      set_config(8'd1, 16'd3);
      random_traffic(60);
      drain_bus();
      repeat (20) @(posedge clock);

      if (errors == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
